// ===== sv/mdbs_pkg.sv =====
`default_nettype none
package mdbs_pkg;

  localparam logic [31:0] INIT_A = 32'h6a09e667;
  localparam logic [31:0] INIT_B = 32'hbb67ae85;
  localparam logic [31:0] INIT_C = 32'h3c6ef372;
  localparam logic [31:0] INIT_D = 32'ha54ff53a;
  localparam logic [31:0] MUL_C  = 32'h9e3779b1;
  localparam int          ROT_D  = 5;

  localparam int DIGEST_WORDS = 8;
  localparam int IDX_W        = $clog2(DIGEST_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGEST_WORDS - 1);

  // Queue depth must be a power of two so that the pointers wrap by themselves.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic        load;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } snap_t;

endpackage
`default_nettype wire

// ===== sv/mdbs_front.sv =====
`default_nettype none
module mdbs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          msg_valid,
  output logic               msg_stall,
  input  wire mdbs_pkg::item_t msg_item,
  output logic               q_valid,
  output mdbs_pkg::item_t    q_item,
  input  wire logic          q_pop
);

  mdbs_pkg::item_t              queue [mdbs_pkg::QDEPTH];
  logic [mdbs_pkg::QPTR_W-1:0]  wr_ptr;
  logic [mdbs_pkg::QPTR_W-1:0]  rd_ptr;
  logic [mdbs_pkg::QCNT_W-1:0]  count;
  logic                         accept;
  logic                         push;

  assign msg_stall = (count == mdbs_pkg::QCNT_W'(mdbs_pkg::QDEPTH));
  assign accept    = msg_valid && !msg_stall;
  // A word that carries no byte and ends nothing has no effect, so it is dropped here.
  assign push      = accept && (msg_item.byte_present || msg_item.end_of_message);

  assign q_valid = (count != '0);
  assign q_item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= msg_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/mdbs_back.sv =====
`default_nettype none
module mdbs_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire mdbs_pkg::item_t q_item,
  output logic                 q_pop,
  input  wire logic            emit_busy,
  output mdbs_pkg::snap_t      snap
);

  logic [31:0] acc_a;
  logic [31:0] acc_b;
  logic [31:0] acc_c;
  logic [31:0] acc_d;
  logic [7:0]  byte_position;

  logic [31:0] acc_a_next;
  logic [31:0] acc_b_next;
  logic [31:0] acc_c_next;
  logic [31:0] acc_d_next;
  logic [8:0]  sum9;
  logic [31:0] prod_c;

  // A closing word has to wait until the previous digest has left the snapshot.
  assign q_pop = q_valid && (!q_item.end_of_message || !emit_busy);

  always_comb begin
    sum9   = {1'b0, q_item.data_byte} + {1'b0, byte_position};
    prod_c = {24'b0, q_item.data_byte} * mdbs_pkg::MUL_C;
    acc_a_next = acc_a;
    acc_b_next = acc_b;
    acc_c_next = acc_c;
    acc_d_next = acc_d;
    if (q_item.byte_present) begin
      acc_a_next = ((acc_a << 5) + acc_a) ^ {23'b0, sum9};
      acc_b_next = ((acc_b << 16) + acc_b) ^ {23'b0, q_item.data_byte, 1'b0};
      acc_c_next = acc_c ^ prod_c;
      acc_d_next = {acc_d[31-mdbs_pkg::ROT_D:0], acc_d[31:32-mdbs_pkg::ROT_D]}
                   ^ {24'b0, q_item.data_byte};
    end
  end

  always_comb begin
    snap.load = q_pop && q_item.end_of_message;
    snap.a    = acc_a_next;
    snap.b    = acc_b_next;
    snap.c    = acc_c_next;
    snap.d    = acc_d_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_a         <= mdbs_pkg::INIT_A;
      acc_b         <= mdbs_pkg::INIT_B;
      acc_c         <= mdbs_pkg::INIT_C;
      acc_d         <= mdbs_pkg::INIT_D;
      byte_position <= '0;
    end else if (q_pop) begin
      if (q_item.end_of_message) begin
        acc_a         <= mdbs_pkg::INIT_A;
        acc_b         <= mdbs_pkg::INIT_B;
        acc_c         <= mdbs_pkg::INIT_C;
        acc_d         <= mdbs_pkg::INIT_D;
        byte_position <= '0;
      end else begin
        acc_a         <= acc_a_next;
        acc_b         <= acc_b_next;
        acc_c         <= acc_c_next;
        acc_d         <= acc_d_next;
        byte_position <= byte_position + 8'(q_item.byte_present);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/mdbs_emit.sv =====
`default_nettype none
module mdbs_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mdbs_pkg::snap_t snap,
  output logic                 busy,
  output logic                 dig_valid,
  input  wire logic            dig_stall,
  output logic [31:0]          digest_word,
  output logic [mdbs_pkg::IDX_W-1:0] word_index,
  output logic                 last_word
);

  logic [31:0]                 snap_a;
  logic [31:0]                 snap_b;
  logic [31:0]                 snap_c;
  logic [31:0]                 snap_d;
  logic [mdbs_pkg::IDX_W-1:0]  cnt;
  logic                        advance;
  logic [31:0]                 word_sel;

  assign advance = busy && (!dig_valid || !dig_stall);

  always_comb begin
    case (cnt)
      3'd0:    word_sel = snap_a;
      3'd1:    word_sel = snap_b;
      3'd2:    word_sel = snap_c;
      3'd3:    word_sel = snap_d;
      3'd4:    word_sel = snap_a ^ snap_b;
      3'd5:    word_sel = snap_b ^ snap_c;
      3'd6:    word_sel = snap_c ^ snap_d;
      default: word_sel = snap_d ^ snap_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (snap.load) begin
      snap_a <= snap.a;
      snap_b <= snap.b;
      snap_c <= snap.c;
      snap_d <= snap.d;
    end
    if (advance) begin
      digest_word <= word_sel;
      word_index  <= cnt;
      last_word   <= (cnt == mdbs_pkg::LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      dig_valid <= 1'b0;
    end else begin
      if (snap.load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (advance) begin
        cnt <= cnt + 1'b1;
        if (cnt == mdbs_pkg::LAST_IDX) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        dig_valid <= 1'b1;
      end else if (!dig_stall) begin
        dig_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/mock_digest_byte_stream.sv =====
`default_nettype none
// Channel   Handshake             Payload
// message   msg_valid/msg_stall   data_byte, byte_present, end_of_message
// digest    dig_valid/dig_stall   digest_word, word_index, last_word
//
// One message word is taken per cycle while msg_stall is low; a four-entry queue separates
// intake from absorption. A closing word puts out its eight digest words from a snapshot,
// while bytes of the next message go on being absorbed; a second closing word waits for it.
// Reset is synchronous and loads the initial constants with position zero.
// A stalled digest word holds in the output register, and absorption carries on until a
// closing word meets a busy snapshot; only then does the queue fill and stall intake.
module mock_digest_byte_stream (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  output logic             dig_valid,
  input  wire logic        dig_stall,
  output logic [31:0]      digest_word,
  output logic [mdbs_pkg::IDX_W-1:0] word_index,
  output logic             last_word
);

  mdbs_pkg::item_t msg_item;
  mdbs_pkg::item_t q_item;
  mdbs_pkg::snap_t snap;
  logic            q_valid;
  logic            q_pop;
  logic            emit_busy;

  always_comb begin
    msg_item.data_byte      = data_byte;
    msg_item.byte_present   = byte_present;
    msg_item.end_of_message = end_of_message;
  end

  mdbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_item  (msg_item),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  mdbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .emit_busy (emit_busy),
    .snap      (snap)
  );

  mdbs_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .snap        (snap),
    .busy        (emit_busy),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule
`default_nettype wire
